// File: hw/rtl/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

	typedef enum logic {
		OP_SET = 1'b0,
		OP_GET = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_HIT      = 3'd3,
		ST_MISS     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

// File: hw/rtl/key_value_table.sv
// Fixed-capacity key/value table. A transfer on the s_ side carries one set (insert or
// update) or one get (lookup); each produces exactly one result transfer on the m_ side.
// Keys are held in one RAM and values in another, both read at the same address; a single
// comparator walks the stored entries from slot 0 upward, one slot per cycle, and stops at
// the first match. An item is accepted in S_IDLE, compares slots in S_SCAN (at most the
// current entry count, none on an empty table) and leaves S_FINISH once the output
// register is free. s_tready is high only between items. Entries are never removed; a set
// of a new key on a full table is dropped with a full status. Bits of key or value above
// KEY_WIDTH or VALUE_WIDTH are ignored.
`default_nettype none

module key_value_table #(
	parameter int CAPACITY    = 128,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] key, [63:32] value
	input  logic        s_tuser,  // [0] opcode

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] read_value
	output logic [2:0]  m_tuser   // [2:0] status
);

	import kvt_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	state_t state_q, state_d;

	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       slot_q;
	logic                   found_q;
	opcode_t                op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [VALUE_WIDTH-1:0] hit_val_q;

	logic                   m_tvalid_q;
	logic [31:0]            m_tdata_q;
	logic [2:0]             m_tuser_q;

	logic [63:0]            key_ext;
	logic [63:0]            val_ext;
	logic [63:0]            hit_ext;

	logic [IDX_W-1:0]       rd_addr;
	logic [IDX_W-1:0]       wr_addr;
	logic                   key_we;
	logic                   val_we;
	logic [KEY_WIDTH-1:0]   key_rdata;
	logic [VALUE_WIDTH-1:0] val_rdata;

	logic                   in_xfer;
	logic                   out_free;
	logic                   load_out;
	logic                   match;
	logic                   last;
	logic                   full;
	status_t                status;

	assign key_ext = {32'b0, s_tdata[31:0]};
	assign val_ext = {32'b0, s_tdata[63:32]};
	assign hit_ext = 64'(hit_val_q);

	assign in_xfer  = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign match    = (key_rdata == key_q);
	assign last     = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign full     = (count_q == CAP_C);

	kvt_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (CAPACITY)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (wr_addr),
		.wdata (key_q),
		.raddr (rd_addr),
		.rdata (key_rdata)
	);

	kvt_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (wr_addr),
		.wdata (val_q),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		load_out = 1'b0;
		key_we   = 1'b0;
		val_we   = 1'b0;
		rd_addr  = '0;
		wr_addr  = found_q ? slot_q : count_q[IDX_W-1:0];
		status   = ST_MISS;

		if (op_q == OP_SET) begin
			if (found_q) begin
				status = ST_UPDATED;
			end else if (!full) begin
				status = ST_INSERTED;
			end else begin
				status = ST_FULL;
			end
		end else begin
			status = found_q ? ST_HIT : ST_MISS;
		end

		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (count_q == '0) ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				rd_addr = idx_q + IDX_W'(1);
				if (match || last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					load_out = 1'b1;
					key_we   = (status == ST_INSERTED);
					val_we   = (status == ST_INSERTED) || (status == ST_UPDATED);
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// scan datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= opcode_t'(s_tuser);
			key_q   <= key_ext[KEY_WIDTH-1:0];
			val_q   <= val_ext[VALUE_WIDTH-1:0];
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (state_q == S_SCAN) begin
			if (match) begin
				found_q   <= 1'b1;
				slot_q    <= idx_q;
				hit_val_q <= val_rdata;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (key_we) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tuser_q <= status;
			m_tdata_q <= (status == ST_HIT) ? hit_ext[31:0] : 32'd0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && status == ST_INSERTED) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not advance entry count");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && status == ST_FULL) |-> (full && !key_we && !val_we))
		else $error("full status without a full table, or a write on drop");

	a_scan_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (!s_tready && count_q != '0))
		else $error("scan running on empty table or with input open");

endmodule

`default_nettype wire

// File: hw/rtl/kvt_ram.sv
`default_nettype none

module kvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import kvt_pkg::*;

	localparam int CAPACITY   = 128;
	localparam int N_RANDOM   = 600;
	localparam int HOLD_LEN   = 600;
	localparam int TAIL       = 2 * CAPACITY + 10;
	localparam int CYCLE_CAP  = 1000000;
	localparam int N_DIRECTED = 17;

	typedef struct {
		status_t     st;
		logic [31:0] rv;
	} answer_t;

	typedef struct {
		opcode_t     op;
		logic [31:0] key;
		logic [31:0] val;
		bit          chk;
		status_t     st;
		logic [31:0] rv;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = OP_SET;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	logic [31:0] tbl_keys [CAPACITY];
	logic [31:0] tbl_vals [CAPACITY];
	int          tbl_count = 0;

	answer_t     pending_answers [$];
	answer_t     oldest;
	row_t        dir_rows [N_DIRECTED];
	int          errors = 0;
	int          items_in = 0;
	int          results_seen = 0;
	int          st_seen [8];
	int          cycles = 0;
	bit          tx_quiet = 1'b0;

	key_value_table #(.CAPACITY(CAPACITY)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// lowest slot holding the key, -1 if absent
	function automatic int table_find(input logic [31:0] k);
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_keys[i] == k)
				return i;
		end
		return -1;
	endfunction

	function automatic answer_t table_apply(input opcode_t op, input logic [31:0] k,
			input logic [31:0] v);
		answer_t a;
		int      slot;
		slot = table_find(k);
		a.rv = '0;
		if (op == OP_SET) begin
			if (slot >= 0) begin
				tbl_vals[slot] = v;
				a.st = ST_UPDATED;
			end else if (tbl_count < CAPACITY) begin
				tbl_keys[tbl_count] = k;
				tbl_vals[tbl_count] = v;
				tbl_count++;
				a.st = ST_INSERTED;
			end else begin
				a.st = ST_FULL;
			end
		end else if (slot >= 0) begin
			a.st = ST_HIT;
			a.rv = tbl_vals[slot];
		end else begin
			a.st = ST_MISS;
		end
		return a;
	endfunction

	function automatic logic [31:0] fresh_key();
		logic [31:0] k;
		do
			k = $urandom;
		while (table_find(k) >= 0);
		return k;
	endfunction

	function automatic logic [31:0] pick_key(input bit want_stored);
		logic [31:0] k;
		int          r;
		r = $urandom_range(99);
		if (want_stored && tbl_count > 0)
			k = tbl_keys[$urandom_range(tbl_count - 1)];
		else if (r < 15 && tbl_count > 0)
			k = tbl_keys[$urandom_range(tbl_count - 1)] ^ (32'd1 << $urandom_range(31));
		else if (r < 20)
			k = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
		else
			k = $urandom;
		return k;
	endfunction

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 32'h0;
		if (r < 10)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	task automatic put_item(input opcode_t op, input logic [31:0] k, input logic [31:0] v,
			input bit chk, input status_t want_st, input logic [31:0] want_rv);
		answer_t a;
		while (!tx_quiet && $urandom_range(99) < 19) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom};
			s_tuser  <= 1'($urandom_range(1));
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {v, k};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		a = table_apply(op, k, v);
		if (chk) begin
			a.st = want_st;
			a.rv = want_rv;
		end
		pending_answers.push_back(a);
		items_in++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			st_seen[m_tuser]++;
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected transfer, status %0d value %h", $time, m_tuser,
					m_tdata);
				errors++;
			end else begin
				oldest = pending_answers.pop_front();
				if (m_tuser !== oldest.st) begin
					$display("%0t: status expected %0d got %0d", $time, oldest.st, m_tuser);
					errors++;
				end
				if (m_tdata !== oldest.rv) begin
					$display("%0t: read_value expected %h got %h", $time, oldest.rv,
						m_tdata);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("%0t: timeout, %0d results still pending", $time, pending_answers.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stalls, a quiet window, and one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 150) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_LEN)
					@(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= (results_seen >= 300 && results_seen < 420) ||
					$urandom_range(99) >= 19;
			end
		end
	end

	initial begin
		opcode_t     op;
		logic [31:0] k;
		for (int i = 0; i < 8; i++)
			st_seen[i] = 0;
		dir_rows = '{
			'{OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_MISS,     32'h0},
			'{OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_MISS,     32'h0},
			'{OP_SET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, 32'h0},
			'{OP_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_INSERTED, 32'h0},
			'{OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_HIT,      32'hFFFF_FFFF},
			'{OP_GET, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, ST_HIT,      32'h0},
			'{OP_SET, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_UPDATED,  32'h0},
			'{OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_HIT,      32'h0},
			'{OP_SET, 32'h8000_0000, 32'h0000_0001, 1'b1, ST_INSERTED, 32'h0},
			'{OP_SET, 32'h0000_0001, 32'h8000_0000, 1'b1, ST_INSERTED, 32'h0},
			'{OP_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, ST_HIT,      32'h8000_0000},
			'{OP_GET, 32'h8000_0001, 32'h0000_0000, 1'b1, ST_MISS,     32'h0},
			'{OP_SET, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1, ST_UPDATED,  32'h0},
			'{OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_HIT,      32'hA5A5_A5A5},
			'{OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, ST_MISS,     32'h0},
			'{OP_SET, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 1'b0, ST_MISS,     32'h0},
			'{OP_GET, 32'h5A5A_5A5A, 32'h0000_0000, 1'b0, ST_MISS,     32'h0}
		};

		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			put_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].val, dir_rows[i].chk,
				dir_rows[i].st, dir_rows[i].rv);

		for (int i = 0; i < N_RANDOM; i++) begin
			tx_quiet = (i >= 250 && i < 350);
			op = ($urandom_range(99) < 55) ? OP_SET : OP_GET;
			if (op == OP_SET)
				k = pick_key($urandom_range(99) < 40);
			else
				k = pick_key($urandom_range(99) < 70);
			put_item(op, k, pick_value(), 1'b0, ST_MISS, 32'h0);
		end
		tx_quiet = 1'b0;

		// make sure the full-table cases are reached
		while (tbl_count < CAPACITY)
			put_item(OP_SET, fresh_key(), pick_value(), 1'b0, ST_MISS, 32'h0);
		repeat (4)
			put_item(OP_SET, fresh_key(), pick_value(), 1'b0, ST_MISS, 32'h0);
		put_item(OP_SET, tbl_keys[CAPACITY - 1], pick_value(), 1'b0, ST_MISS, 32'h0);
		put_item(OP_GET, tbl_keys[CAPACITY - 1], pick_value(), 1'b0, ST_MISS, 32'h0);
		put_item(OP_GET, fresh_key(), pick_value(), 1'b0, ST_MISS, 32'h0);

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (TAIL)
			@(posedge clk);

		$display("%0d transfers in, %0d out: %0d inserted, %0d updated, %0d dropped full",
			items_in, results_seen, st_seen[ST_INSERTED], st_seen[ST_UPDATED],
			st_seen[ST_FULL]);
		$display("%0d hits, %0d misses, %0d entries stored, %0d mismatches",
			st_seen[ST_HIT], st_seen[ST_MISS], tbl_count, errors);
		if (errors == 0 && pending_answers.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/kvt_pkg.sv
hw/rtl/kvt_ram.sv
hw/rtl/key_value_table.sv
tb/tb_top.sv
